### sv/dpvc_pkg.sv
// ----------------------------------------------------------------------------
// Differential pump valve controller package
// Shared widths, register indexes and the types passed between the modules.
// ----------------------------------------------------------------------------
package dpvc_pkg;

  localparam int CoeffBits  = 48;
  localparam int FracBits   = 32;
  localparam int TempBits   = 16;
  localparam int GapBits    = 6;
  localparam int ThrBits    = 12;
  localparam int LevelBits  = 3;
  localparam int DigitBits  = 4;
  localparam int CfgIdxBits = 3;

  localparam logic [ThrBits-1:0]    ThrReset  = 12'd2000;
  localparam logic [LevelBits-1:0]  LevelFull = 3'd5;
  localparam logic [LevelBits-1:0]  LevelFour = 3'd4;
  localparam logic [LevelBits-1:0]  LevelThree = 3'd3;
  localparam logic [LevelBits-1:0]  LevelTwo  = 3'd2;
  localparam logic [LevelBits-1:0]  LevelOne  = 3'd1;
  localparam logic [LevelBits-1:0]  LevelEmpty = 3'd0;

  localparam logic [CfgIdxBits-1:0] RegCoeffSquare   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegCoeffLinear   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegCoeffOffset   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegStoreGap      = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegActiveGap     = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegEndGap        = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegLevelThreshold = 3'd6;

  typedef struct packed {
    logic [CoeffBits-1:0] square;
    logic [CoeffBits-1:0] linear;
    logic [CoeffBits-1:0] offset;
  } coeff_t;

  typedef struct packed {
    logic                done;
    logic [TempBits-1:0] temp;
  } poly_rsp_t;

endpackage

### sv/dpvc_if.sv
// ----------------------------------------------------------------------------
// Differential pump valve controller channels
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dpvc_sample_if #(
  parameter int SensorBits = 12
);
  logic                  valid;
  logic                  ready;
  logic [SensorBits-1:0] temp_active_raw;
  logic [SensorBits-1:0] temp_end_raw;
  logic [SensorBits-1:0] temp_ref_raw;
  logic [SensorBits-1:0] temp_store_raw;
  logic [SensorBits-1:0] level_one;
  logic [SensorBits-1:0] level_two;
  logic [SensorBits-1:0] level_three;
  logic [SensorBits-1:0] level_four;
  logic [SensorBits-1:0] level_five;

  modport source (
    output valid, temp_active_raw, temp_end_raw, temp_ref_raw, temp_store_raw,
           level_one, level_two, level_three, level_four, level_five,
    input  ready
  );
  modport sink (
    input  valid, temp_active_raw, temp_end_raw, temp_ref_raw, temp_store_raw,
           level_one, level_two, level_three, level_four, level_five,
    output ready
  );
endinterface

interface dpvc_result_if;
  logic                           valid;
  logic                           ready;
  logic                           pump_on;
  logic                           valve_on;
  logic [dpvc_pkg::LevelBits-1:0] tank_level;

  modport source (output valid, pump_on, valve_on, tank_level, input ready);
  modport sink   (input  valid, pump_on, valve_on, tank_level, output ready);
endinterface

interface dpvc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dpvc_pkg::CfgIdxBits-1:0] index;
  logic [dpvc_pkg::CoeffBits-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

### sv/dpvc_poly.sv
// ----------------------------------------------------------------------------
// Digit-serial temperature polynomial
// Evaluates ((square * x + linear) * x + offset) exactly, one 4-bit digit of x
// per cycle, then clamps the integer part to the 16-bit temperature range.
// ----------------------------------------------------------------------------
module dpvc_poly #(
  parameter int SensorBits = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SensorBits-1:0] x_i,
  input  dpvc_pkg::coeff_t      coeff_i,
  output dpvc_pkg::poly_rsp_t   rsp_o
);
  import dpvc_pkg::*;

  localparam int NumDigits = (SensorBits + DigitBits - 1) / DigitBits;
  localparam int XBits     = NumDigits * DigitBits;
  localparam int MulBits   = CoeffBits + XBits + 1;
  localparam int AccBits   = CoeffBits + 2 * XBits + 2;
  localparam int ProdBits  = MulBits + DigitBits + 1;
  localparam int CntBits   = $clog2(NumDigits);

  localparam logic [1:0] PIdle = 2'd0;
  localparam logic [1:0] PMul  = 2'd1;
  localparam logic [1:0] PAdd  = 2'd2;
  localparam logic [1:0] PDone = 2'd3;

  logic [1:0]                state_q, state_d;
  logic                      pass_q, pass_d;
  logic [CntBits-1:0]        cnt_q, cnt_d;
  logic [XBits-1:0]          x_sh_q, x_sh_d;
  logic signed [MulBits-1:0] m_q, m_d;
  logic signed [AccBits-1:0] acc_q, acc_d;

  logic [DigitBits-1:0]       digit;
  logic signed [ProdBits-1:0] prod;
  logic signed [AccBits-1:0]  prod_ext;
  logic signed [AccBits-1:0]  lin_ext;
  logic signed [AccBits-1:0]  off_ext;
  logic signed [AccBits-1:0]  acc_sum;
  logic                       over;

  assign digit    = x_sh_q[XBits-1 -: DigitBits];
  assign prod     = m_q * $signed({1'b0, digit});
  assign prod_ext = $signed({{(AccBits - ProdBits){prod[ProdBits-1]}}, prod});
  assign lin_ext  = $signed({{(AccBits - CoeffBits){coeff_i.linear[CoeffBits-1]}},
                             coeff_i.linear});
  assign off_ext  = $signed({{(AccBits - CoeffBits){coeff_i.offset[CoeffBits-1]}},
                             coeff_i.offset});
  assign acc_sum  = acc_q + (pass_q ? off_ext : lin_ext);

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cnt_d   = cnt_q;
    x_sh_d  = x_sh_q;
    m_d     = m_q;
    acc_d   = acc_q;
    unique case (state_q)
      PIdle: begin
        if (start_i) begin
          x_sh_d  = XBits'(x_i);
          m_d     = $signed({{(MulBits - CoeffBits){coeff_i.square[CoeffBits-1]}},
                             coeff_i.square});
          acc_d   = '0;
          pass_d  = 1'b0;
          cnt_d   = '0;
          state_d = PMul;
        end
      end
      PMul: begin
        acc_d  = (acc_q <<< DigitBits) + prod_ext;
        x_sh_d = {x_sh_q[XBits-DigitBits-1:0], x_sh_q[XBits-1 -: DigitBits]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntBits'(NumDigits - 1)) begin
          state_d = PAdd;
        end
      end
      PAdd: begin
        cnt_d = '0;
        if (pass_q) begin
          acc_d   = acc_sum;
          state_d = PDone;
        end else begin
          m_d     = acc_sum[MulBits-1:0];
          acc_d   = '0;
          pass_d  = 1'b1;
          state_d = PMul;
        end
      end
      PDone: begin
        state_d = PIdle;
      end
      default: begin
        state_d = PIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PIdle;
      pass_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_sh_q <= x_sh_d;
    m_q    <= m_d;
    acc_q  <= acc_d;
  end

  assign over = |acc_q[AccBits-2:FracBits+TempBits];

  always_comb begin
    rsp_o.done = (state_q == PDone);
    if (acc_q[AccBits-1]) begin
      rsp_o.temp = '0;
    end else if (over) begin
      rsp_o.temp = '1;
    end else begin
      rsp_o.temp = acc_q[FracBits+TempBits-1:FracBits];
    end
  end

endmodule

### sv/differential_pump_valve_controller.sv
// ----------------------------------------------------------------------------
// Differential pump valve controller
// Classifies the tank level, converts four temperatures and drives pump/valve.
// ----------------------------------------------------------------------------
// One sample set is taken at a time. Its four temperatures are converted one
// after another on a single digit-serial multiply-accumulate unit that eats
// four bits of the reading per cycle. The result register lets the next
// sample set be taken while a result waits. Configuration writes are taken in
// every cycle and must happen while idle.
// ----------------------------------------------------------------------------
module differential_pump_valve_controller #(
  parameter int SensorBits = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dpvc_sample_if.sink   sample_i,
  dpvc_result_if.source result_o,
  dpvc_cfg_if.sink      cfg_i
);
  import dpvc_pkg::*;

  localparam int LvlBits  = (SensorBits > ThrBits) ? SensorBits : ThrBits;
  localparam int DiffBits = TempBits + 2;

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SStart  = 2'd1;
  localparam logic [1:0] SWait   = 2'd2;
  localparam logic [1:0] SDecide = 2'd3;

  coeff_t             coeff_q;
  logic [GapBits-1:0] store_gap_q;
  logic [GapBits-1:0] active_gap_q;
  logic [GapBits-1:0] end_gap_q;
  logic [ThrBits-1:0] thr_q;

  logic [1:0]            state_q, state_d;
  logic [1:0]            tidx_q, tidx_d;
  logic [SensorBits-1:0] raw_q [4];
  logic [SensorBits-1:0] lvl_q [5];
  logic [TempBits-1:0]   temp_q [4];

  logic                 pump_q, valve_q;
  logic                 out_valid_q;
  logic [LevelBits-1:0] level_q;

  logic                 in_accept;
  logic                 out_free;
  logic                 load;
  poly_rsp_t            rsp;
  logic [LevelBits-1:0] level;
  logic [LvlBits-1:0]   thr_ext;
  logic signed [DiffBits-1:0] d_sto, d_act, d_end;
  logic                 set_cond, reset_cond;
  logic                 pump_n, valve_n;

  assign cfg_i.ready     = 1'b1;
  assign sample_i.ready  = (state_q == SIdle);
  assign in_accept       = sample_i.valid && sample_i.ready;
  assign out_free        = !out_valid_q || result_o.ready;
  assign load            = (state_q == SDecide) && out_free;

  dpvc_poly #(
    .SensorBits(SensorBits)
  ) u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == SStart),
    .x_i    (raw_q[tidx_q]),
    .coeff_i(coeff_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q      <= '0;
      store_gap_q  <= '0;
      active_gap_q <= '0;
      end_gap_q    <= '0;
      thr_q        <= ThrReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegCoeffSquare:    coeff_q.square <= cfg_i.data;
        RegCoeffLinear:    coeff_q.linear <= cfg_i.data;
        RegCoeffOffset:    coeff_q.offset <= cfg_i.data;
        RegStoreGap:       store_gap_q    <= cfg_i.data[GapBits-1:0];
        RegActiveGap:      active_gap_q   <= cfg_i.data[GapBits-1:0];
        RegEndGap:         end_gap_q      <= cfg_i.data[GapBits-1:0];
        RegLevelThreshold: thr_q          <= cfg_i.data[ThrBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    tidx_d  = tidx_q;
    unique case (state_q)
      SIdle: begin
        if (in_accept) begin
          tidx_d  = '0;
          state_d = SStart;
        end
      end
      SStart: begin
        state_d = SWait;
      end
      SWait: begin
        if (rsp.done) begin
          if (tidx_q == 2'd3) begin
            state_d = SDecide;
          end else begin
            tidx_d  = tidx_q + 1'b1;
            state_d = SStart;
          end
        end
      end
      SDecide: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      tidx_q      <= '0;
      out_valid_q <= 1'b0;
      pump_q      <= 1'b0;
      valve_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      tidx_q  <= tidx_d;
      if (load) begin
        out_valid_q <= 1'b1;
        pump_q      <= pump_n;
        valve_q     <= valve_n;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q[0] <= sample_i.temp_active_raw;
      raw_q[1] <= sample_i.temp_end_raw;
      raw_q[2] <= sample_i.temp_ref_raw;
      raw_q[3] <= sample_i.temp_store_raw;
      lvl_q[0] <= sample_i.level_one;
      lvl_q[1] <= sample_i.level_two;
      lvl_q[2] <= sample_i.level_three;
      lvl_q[3] <= sample_i.level_four;
      lvl_q[4] <= sample_i.level_five;
    end
    if ((state_q == SWait) && rsp.done) begin
      temp_q[tidx_q] <= rsp.temp;
    end
    if (load) begin
      level_q <= level;
    end
  end

  // The top probe tests for wet, the others for dry.
  assign thr_ext = LvlBits'(thr_q);

  always_comb begin
    if (LvlBits'(lvl_q[4]) > thr_ext) begin
      level = LevelFull;
    end else if (LvlBits'(lvl_q[3]) < thr_ext) begin
      level = LevelFour;
    end else if (LvlBits'(lvl_q[2]) < thr_ext) begin
      level = LevelThree;
    end else if (LvlBits'(lvl_q[1]) < thr_ext) begin
      level = LevelTwo;
    end else if (LvlBits'(lvl_q[0]) < thr_ext) begin
      level = LevelOne;
    end else begin
      level = LevelEmpty;
    end
  end

  assign d_sto = $signed({2'b00, temp_q[2]}) - $signed({2'b00, temp_q[3]});
  assign d_act = $signed({2'b00, temp_q[2]}) - $signed({2'b00, temp_q[0]});
  assign d_end = $signed({2'b00, temp_q[2]}) - $signed({2'b00, temp_q[1]});

  assign set_cond   = (d_sto >= $signed(DiffBits'(store_gap_q))) &&
                      (d_act <= $signed(DiffBits'(active_gap_q)));
  assign reset_cond = (d_end >= $signed(DiffBits'(end_gap_q)));

  always_comb begin
    pump_n  = pump_q;
    valve_n = valve_q;
    if (level == LevelFull) begin
      valve_n = 1'b0;
      if (reset_cond) begin
        pump_n = 1'b0;
      end else if (set_cond) begin
        pump_n = 1'b1;
      end
    end else begin
      pump_n = 1'b0;
      if (reset_cond) begin
        valve_n = 1'b0;
      end else if (set_cond) begin
        valve_n = 1'b1;
      end
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.pump_on    = pump_q;
  assign result_o.valve_on   = valve_q;
  assign result_o.tank_level = level_q;

endmodule

### tb/dpvc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pump valve controller scoreboard
// Holds a bit-exact copy of the register set and the pump/valve state, works
// out the drive and tank level for each accepted request and checks results.
// ----------------------------------------------------------------------------
package dpvc_tb_pkg;

  import dpvc_pkg::*;

  localparam int SensorBits = 12;
  localparam int TempMax    = 65535;
  localparam int WideBits   = 96;

  localparam logic [CfgIdxBits-1:0] RegUnmapped = 3'd7;

  typedef struct packed {
    logic [SensorBits-1:0]      t_active;
    logic [SensorBits-1:0]      t_end;
    logic [SensorBits-1:0]      t_ref;
    logic [SensorBits-1:0]      t_store;
    logic [4:0][SensorBits-1:0] probe;
  } sample_t;

  typedef struct packed {
    logic                 pump;
    logic                 valve;
    logic [LevelBits-1:0] level;
  } drive_t;

  class pump_valve_scoreboard;
    logic [CoeffBits-1:0] square;
    logic [CoeffBits-1:0] linear;
    logic [CoeffBits-1:0] offset;
    logic [GapBits-1:0]   store_gap;
    logic [GapBits-1:0]   active_gap;
    logic [GapBits-1:0]   end_gap;
    logic [ThrBits-1:0]   thr;
    logic                 pump;
    logic                 valve;
    drive_t               drive_q[$];
    int                   errors;
    int                   checked;
    int                   level_hits[6];
    int                   pump_ons;
    int                   valve_ons;

    function new();
      square     = '0;
      linear     = '0;
      offset     = '0;
      store_gap  = '0;
      active_gap = '0;
      end_gap    = '0;
      thr        = ThrReset;
      pump       = 1'b0;
      valve      = 1'b0;
      errors     = 0;
      checked    = 0;
      pump_ons   = 0;
      valve_ons  = 0;
      foreach (level_hits[i]) level_hits[i] = 0;
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CoeffBits-1:0] data);
      case (idx)
        RegCoeffSquare:    square     = data;
        RegCoeffLinear:    linear     = data;
        RegCoeffOffset:    offset     = data;
        RegStoreGap:       store_gap  = data[GapBits-1:0];
        RegActiveGap:      active_gap = data[GapBits-1:0];
        RegEndGap:         end_gap    = data[GapBits-1:0];
        RegLevelThreshold: thr        = data[ThrBits-1:0];
        default: ;
      endcase
    endfunction

    // The polynomial is evaluated exactly in a wide signed accumulator.
    function int temp_of(logic [SensorBits-1:0] raw);
      logic signed [WideBits-1:0] x;
      logic signed [WideBits-1:0] acc;
      x   = $signed({{(WideBits-SensorBits){1'b0}}, raw});
      acc = $signed({{(WideBits-CoeffBits){square[CoeffBits-1]}}, square}) * x * x
          + $signed({{(WideBits-CoeffBits){linear[CoeffBits-1]}}, linear}) * x
          + $signed({{(WideBits-CoeffBits){offset[CoeffBits-1]}}, offset});
      if (acc < 0) return 0;
      acc = acc >>> FracBits;
      if (acc > TempMax) return TempMax;
      return int'(acc);
    endfunction

    function void note_sample(sample_t s);
      int                   ta;
      int                   te;
      int                   tr;
      int                   ts;
      logic [LevelBits-1:0] lvl;
      logic                 set_c;
      logic                 reset_c;
      drive_t               d;
      ta = temp_of(s.t_active);
      te = temp_of(s.t_end);
      tr = temp_of(s.t_ref);
      ts = temp_of(s.t_store);
      if (s.probe[4] > thr) lvl = LevelFull;
      else if (s.probe[3] < thr) lvl = LevelFour;
      else if (s.probe[2] < thr) lvl = LevelThree;
      else if (s.probe[1] < thr) lvl = LevelTwo;
      else if (s.probe[0] < thr) lvl = LevelOne;
      else lvl = LevelEmpty;
      set_c   = ((tr - ts) >= int'(store_gap)) && ((tr - ta) <= int'(active_gap));
      reset_c = (tr - te) >= int'(end_gap);
      if (lvl == LevelFull) begin
        valve = 1'b0;
        if (set_c) pump = 1'b1;
        if (reset_c) pump = 1'b0;
      end else begin
        pump = 1'b0;
        if (set_c) valve = 1'b1;
        if (reset_c) valve = 1'b0;
      end
      d.pump  = pump;
      d.valve = valve;
      d.level = lvl;
      drive_q.push_back(d);
    endfunction

    function void check_result(logic pump_o, logic valve_o, logic [LevelBits-1:0] level_o);
      drive_t d;
      if (drive_q.size() == 0) begin
        $error("unexpected result: pump_on %0b valve_on %0b tank_level %0d",
               pump_o, valve_o, level_o);
        errors++;
        return;
      end
      d = drive_q.pop_front();
      checked++;
      level_hits[d.level]++;
      pump_ons  += int'(d.pump);
      valve_ons += int'(d.valve);
      if (pump_o !== d.pump) begin
        $error("pump_on: expected %0b, actual %0b", d.pump, pump_o);
        errors++;
      end
      if (valve_o !== d.valve) begin
        $error("valve_on: expected %0b, actual %0b", d.valve, valve_o);
        errors++;
      end
      if (level_o !== d.level) begin
        $error("tank_level: expected %0d, actual %0d", d.level, level_o);
        errors++;
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

endpackage

### tb/differential_pump_valve_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Differential pump valve controller testbench
// Walks the level chain, the set and reset tests and the temperature clamps
// under directed register settings, then runs randomized phases with fresh
// coefficients, gaps and thresholds and random stalls on both channels.
// ----------------------------------------------------------------------------
module differential_pump_valve_controller_tb;

  import dpvc_pkg::*;
  import dpvc_tb_pkg::*;

  localparam int SettleCycles = 60;
  localparam int RandomPhases = 12;
  localparam int PhaseItems   = 142;

  logic clk;
  logic rst_n;
  logic calm;
  int   sent;
  int   settings;

  pump_valve_scoreboard board;

  dpvc_sample_if #(.SensorBits(SensorBits)) smp();
  dpvc_result_if res();
  dpvc_cfg_if    cfg();

  differential_pump_valve_controller #(.SensorBits(SensorBits)) u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (smp),
    .result_o (res),
    .cfg_i    (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pause();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [SensorBits-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return v[SensorBits-1:0];
  endfunction

  function automatic sample_t mk(int act, int fin, int rf, int sto,
                                 int l1, int l2, int l3, int l4, int l5);
    sample_t s;
    s.t_active = SensorBits'(act);
    s.t_end    = SensorBits'(fin);
    s.t_ref    = SensorBits'(rf);
    s.t_store  = SensorBits'(sto);
    s.probe[0] = SensorBits'(l1);
    s.probe[1] = SensorBits'(l2);
    s.probe[2] = SensorBits'(l3);
    s.probe[3] = SensorBits'(l4);
    s.probe[4] = SensorBits'(l5);
    return s;
  endfunction

  function automatic logic [SensorBits-1:0] probe_near(int thr);
    case ($urandom_range(0, 3))
      0: return clip($urandom_range(0, 4095));
      1: return clip(thr);
      2: return clip(thr + int'($urandom_range(1, 40)));
      default: return clip(thr - int'($urandom_range(1, 40)));
    endcase
  endfunction

  // Most requests keep the four temperatures close together so that the
  // differences land around the programmed gaps.
  function automatic sample_t random_sample();
    sample_t s;
    int      r;
    int      thr;
    thr = int'(board.thr);
    if ($urandom_range(0, 4) == 0) begin
      s = mk($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
             $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
             $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      r = $urandom_range(0, 4095);
      s.t_ref    = clip(r);
      s.t_store  = clip(r - int'($urandom_range(0, 90)) + 15);
      s.t_active = clip(r - int'($urandom_range(0, 90)) + 15);
      s.t_end    = clip(r - int'($urandom_range(0, 90)) + 15);
      for (int i = 0; i < 4; i++) s.probe[i] = probe_near(thr);
      if ($urandom_range(0, 2) == 0) s.probe[4] = clip(thr + 1 + int'($urandom_range(0, 200)));
      else s.probe[4] = probe_near(thr);
    end
    return s;
  endfunction

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [CoeffBits-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    board.set_reg(idx, data);
  endtask

  task automatic load_config(logic [CoeffBits-1:0] sq, logic [CoeffBits-1:0] lin,
                             logic [CoeffBits-1:0] off, logic [CoeffBits-1:0] sg,
                             logic [CoeffBits-1:0] ag, logic [CoeffBits-1:0] eg,
                             logic [CoeffBits-1:0] thr);
    cfg_write(RegCoeffSquare, sq);
    cfg_write(RegCoeffLinear, lin);
    cfg_write(RegCoeffOffset, off);
    cfg_write(RegStoreGap, sg);
    cfg_write(RegActiveGap, ag);
    cfg_write(RegEndGap, eg);
    cfg_write(RegLevelThreshold, thr);
    cfg.valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [CoeffBits-1:0] random_gap();
    logic [CoeffBits-1:0] g;
    case ($urandom_range(0, 5))
      0: g = 0;
      1: g = 50;
      2: g = 63;
      default: g = 48'($urandom_range(0, 63));
    endcase
    if ($urandom_range(0, 3) == 0) g = (48'({$urandom, $urandom}) & ~48'h3F) | g;
    return g;
  endfunction

  task automatic random_config();
    logic [CoeffBits-1:0] sq;
    logic [CoeffBits-1:0] lin;
    logic [CoeffBits-1:0] off;
    logic [CoeffBits-1:0] thr;
    sq  = '0;
    lin = 48'($urandom_range(1, 3)) << FracBits;
    off = '0;
    case ($urandom_range(0, 3))
      0: begin
        lin = (48'($urandom_range(0, 2)) << FracBits) | 48'($urandom);
        off = (48'($urandom_range(0, 300)) << FracBits) | 48'($urandom);
        if ($urandom_range(0, 1) == 1) off = -off;
      end
      1: begin
        sq  = 48'($urandom_range(0, 1 << 21));
        if ($urandom_range(0, 3) == 0) sq = -sq;
        lin = 48'($urandom);
        off = (48'($urandom_range(0, 300)) << FracBits) | 48'($urandom);
        if ($urandom_range(0, 1) == 1) off = -off;
      end
      2: begin
        sq  = 48'({$urandom, $urandom});
        lin = 48'({$urandom, $urandom});
        off = 48'({$urandom, $urandom});
      end
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: thr = 0;
      1: thr = 4095;
      2: thr = 48'({$urandom, $urandom});
      default: thr = 48'($urandom_range(200, 3900));
    endcase
    if ($urandom_range(0, 3) == 0) cfg_write(RegUnmapped, 48'({$urandom, $urandom}));
    load_config(sq, lin, off, random_gap(), random_gap(), random_gap(), thr);
  endtask

  task automatic send(sample_t s);
    int gap;
    gap = pause();
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid           <= 1'b1;
    smp.temp_active_raw <= s.t_active;
    smp.temp_end_raw    <= s.t_end;
    smp.temp_ref_raw    <= s.t_ref;
    smp.temp_store_raw  <= s.t_store;
    smp.level_one       <= s.probe[0];
    smp.level_two       <= s.probe[1];
    smp.level_three     <= s.probe[2];
    smp.level_four      <= s.probe[3];
    smp.level_five      <= s.probe[4];
    do @(posedge clk); while (!smp.ready);
    board.note_sample(s);
    sent++;
  endtask

  task automatic drain(int extra);
    smp.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    int stall;
    res.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = pause();
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      board.check_result(res.pump_on, res.valve_on, res.tank_level);
    end
  end

  initial begin
    board               = new();
    calm                = 1'b0;
    sent                = 0;
    settings            = 0;
    rst_n               = 1'b0;
    smp.valid           = 1'b0;
    smp.temp_active_raw = '0;
    smp.temp_end_raw    = '0;
    smp.temp_ref_raw    = '0;
    smp.temp_store_raw  = '0;
    smp.level_one       = '0;
    smp.level_two       = '0;
    smp.level_three     = '0;
    smp.level_four      = '0;
    smp.level_five      = '0;
    cfg.valid           = 1'b0;
    cfg.index           = RegCoeffSquare;
    cfg.data            = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset registers every temperature is zero, so the level chain
    // is walked on its own and the reset test always wins.
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    send(mk(0, 0, 0, 0, 2000, 2000, 2000, 2000, 2000));
    send(mk(0, 0, 0, 0, 2000, 2000, 2000, 2000, 2001));
    send(mk(0, 0, 0, 0, 2000, 2000, 2000, 1999, 2000));
    send(mk(0, 0, 0, 0, 2000, 2000, 1999, 2000, 2000));
    send(mk(0, 0, 0, 0, 2000, 1999, 2000, 2000, 2000));
    send(mk(0, 0, 0, 0, 1999, 2000, 2000, 2000, 2000));
    drain(SettleCycles);

    load_config(0, 48'd1 << FracBits, 0, 5, 3, 10, 2000);
    send(mk(999, 1000, 1000, 990, 0, 0, 0, 0, 4095));
    send(mk(999, 1000, 1000, 998, 0, 0, 0, 0, 4095));
    send(mk(999, 990, 1000, 990, 0, 0, 0, 0, 4095));
    send(mk(1003, 1000, 1000, 995, 2000, 2000, 1999, 2000, 0));
    send(mk(997, 1000, 1000, 995, 2000, 2000, 1999, 2000, 0));
    send(mk(996, 1000, 1000, 995, 2000, 2000, 1999, 2000, 0));
    send(mk(996, 1000, 1000, 995, 0, 0, 0, 0, 4095));
    drain(SettleCycles);

    // Saturation above range, a negative polynomial clamped to zero, gaps
    // above fifty and a write to an index that maps to no register.
    cfg_write(RegUnmapped, 48'hFFFF_FFFF_FFFF);
    load_config(48'h7FFF_FFFF_FFFF, 0, 48'h8000_0000_0000, 63, 51, 60, 4095);
    send(mk(4095, 0, 4095, 0, 4095, 4095, 4095, 4095, 4095));
    send(mk(4095, 4095, 4095, 0, 4095, 4095, 4095, 4094, 4095));
    send(mk(1, 1, 2, 0, 0, 0, 0, 0, 0));
    drain(SettleCycles);

    load_config(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0);
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(4095, 2048, 1, 4095, 4095, 4095, 4095, 4095, 1));
    drain(SettleCycles);

    for (int p = 0; p < RandomPhases; p++) begin
      calm = ($urandom_range(0, 2) == 0);
      random_config();
      for (int i = 0; i < PhaseItems; i++) begin
        if (p % 2 == 1 && i == PhaseItems / 2) drain(0);
        send(random_sample());
      end
      drain(SettleCycles);
    end

    $display("Checked %0d results from %0d sample sets under %0d register settings.",
             board.checked, sent, settings);
    $display("Tank levels 0..5 seen %0d/%0d/%0d/%0d/%0d/%0d times, pump on %0d, valve open %0d.",
             board.level_hits[0], board.level_hits[1], board.level_hits[2],
             board.level_hits[3], board.level_hits[4], board.level_hits[5],
             board.pump_ons, board.valve_ons);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
